// ===== rtl/core/y2r_pkg.sv =====
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared widths, reset values, register indexes and BT.601 coefficients.
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 12;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W = 28;

  localparam logic [CFG_W-1:0] LINE_PAIRS_RST      = 12'd320;
  localparam logic [CFG_W-1:0] FRAME_ROW_PAIRS_RST = 12'd240;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_PAIRS      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROW_PAIRS = 1'd1;

  // coefficients scaled by 65536
  localparam logic signed [SUM_W-1:0] K_Y  = 28'sd76310;
  localparam logic signed [SUM_W-1:0] K_RV = 28'sd104595;
  localparam logic signed [SUM_W-1:0] K_GU = 28'sd25677;
  localparam logic signed [SUM_W-1:0] K_GV = 28'sd53281;
  localparam logic signed [SUM_W-1:0] K_BU = 28'sd132199;

  localparam logic signed [PIX_W:0] LUMA_OFS   = 9'sd16;
  localparam logic signed [PIX_W:0] CHROMA_OFS = 9'sd128;

endpackage

// ===== rtl/core/y2r_yuy2_if.sv =====
// ----------------------------------------------------------------------------
// y2r_yuy2_if
// Valid/ready channel carrying one YUY2 macropixel per beat.
// ----------------------------------------------------------------------------
interface y2r_yuy2_if;
  logic                       valid;
  logic                       ready;
  logic [y2r_pkg::PIX_W-1:0]  luma_first;
  logic [y2r_pkg::PIX_W-1:0]  chroma_blue;
  logic [y2r_pkg::PIX_W-1:0]  luma_second;
  logic [y2r_pkg::PIX_W-1:0]  chroma_red;

  modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                  input ready);
  modport sink   (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                  output ready);
endinterface

// ===== rtl/core/y2r_rgb_if.sv =====
// ----------------------------------------------------------------------------
// y2r_rgb_if
// Valid/ready channel carrying two RGB pixels and line/frame flags per beat.
// ----------------------------------------------------------------------------
interface y2r_rgb_if;
  logic                       valid;
  logic                       ready;
  logic [y2r_pkg::PIX_W-1:0]  red_first;
  logic [y2r_pkg::PIX_W-1:0]  green_first;
  logic [y2r_pkg::PIX_W-1:0]  blue_first;
  logic [y2r_pkg::PIX_W-1:0]  red_second;
  logic [y2r_pkg::PIX_W-1:0]  green_second;
  logic [y2r_pkg::PIX_W-1:0]  blue_second;
  logic                       line_end;
  logic                       frame_end;

  modport source (output valid, red_first, green_first, blue_first, red_second,
                  green_second, blue_second, line_end, frame_end,
                  input ready);
  modport sink   (input valid, red_first, green_first, blue_first, red_second,
                  green_second, blue_second, line_end, frame_end,
                  output ready);
endinterface

// ===== rtl/core/yuy2_to_rgb32_converter.sv =====
// ----------------------------------------------------------------------------
// yuy2_to_rgb32_converter
// YUY2 macropixel to two BT.601 studio-range RGB pixels, chroma shared
// vertically across row pairs through a line buffer.
// ----------------------------------------------------------------------------
// in_pix takes one macropixel per beat in raster order; out_pix gives the two
// converted pixels of that beat with line_end and frame_end flags.
// Even rows store their Cb/Cr pair in the chroma line memory at the column;
// odd rows use the stored pair and ignore their own chroma.
// An accepted beat moves through stage 1, stage 2 and stage 3, the output register.
// Throughput: one beat per cycle while out_pix is not stalled; the line memory
// is written and read once per accepted beat on its single port, and the three
// pipeline stages each hold one beat.
// A stall on out_pix holds the output register; the stages behind it fill,
// and in_pix.ready falls only when every stage is occupied.
// cfg_we/cfg_index/cfg_wdata write line_pairs (0) and frame_row_pairs (1);
// write them only while the pipeline is empty.
// Reset clears the counts, valids and restores line_pairs to 320 and
// frame_row_pairs to 240. The line memory is not cleared: an odd row must
// follow the even row that filled its columns.
// ----------------------------------------------------------------------------
module yuy2_to_rgb32_converter #(
  parameter int MAX_LINE_PAIRS = 2048,
  parameter int MAX_ROW_PAIRS  = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  y2r_yuy2_if.sink                        in_pix,
  y2r_rgb_if.source                       out_pix,
  input  logic                            cfg_we,
  input  logic [y2r_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [y2r_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int CW  = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1;
  localparam int RPW = (MAX_ROW_PAIRS > 1) ? $clog2(MAX_ROW_PAIRS) : 1;
  localparam int RW  = RPW + 1;
  localparam int PW  = y2r_pkg::PIX_W;
  localparam int SW  = y2r_pkg::SUM_W;
  localparam int CMPW = y2r_pkg::CFG_W + 2;

  typedef logic signed [SW-1:0] sum_t;

  // configuration
  logic [y2r_pkg::CFG_W-1:0] line_pairs_r;
  logic [y2r_pkg::CFG_W-1:0] frame_row_pairs_r;
  logic [CW-1:0]             pairs_m1;
  logic [RPW-1:0]            rows_m1;

  // counters
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          lend;
  logic          fend;
  logic          accept;

  // line memory
  logic [2*PW-1:0] chroma_mem [MAX_LINE_PAIRS];
  logic [2*PW-1:0] rd_r;

  // stage 1
  logic          s1_valid_r;
  logic [PW-1:0] s1_y0_r, s1_y1_r, s1_cb_r, s1_cr_r;
  logic          s1_odd_r, s1_lend_r, s1_fend_r;

  // stage 2
  logic          s2_valid_r;
  sum_t          s2_yp0_r, s2_yp1_r, s2_rv_r, s2_gu_r, s2_gv_r, s2_bu_r;
  logic          s2_lend_r, s2_fend_r;

  // stage 3 / output
  logic          s3_valid_r;

  logic rdy3, rdy2, rdy1;
  logic [PW-1:0] cb_sel, cr_sel;
  logic signed [PW:0] y0_d, y1_d, u_d, v_d;
  sum_t r0, g0, b0, r1, g1, b1;

  function automatic logic [PW-1:0] to_channel(input sum_t s);
    logic [PW-1:0] q;
    if (s < 0) begin
      q = '0;
    end else if (|s[SW-2:16+PW]) begin
      q = '1;
    end else begin
      q = s[16+PW-1:16];
    end
    return q;
  endfunction

  // register clamping: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (line_pairs_r == '0) begin
      pairs_m1 = '0;
    end else if (CMPW'(line_pairs_r) > CMPW'(MAX_LINE_PAIRS)) begin
      pairs_m1 = CW'(MAX_LINE_PAIRS - 1);
    end else begin
      pairs_m1 = CW'(line_pairs_r - 12'd1);
    end
    if (frame_row_pairs_r == '0) begin
      rows_m1 = '0;
    end else if (CMPW'(frame_row_pairs_r) > CMPW'(MAX_ROW_PAIRS)) begin
      rows_m1 = RPW'(MAX_ROW_PAIRS - 1);
    end else begin
      rows_m1 = RPW'(frame_row_pairs_r - 12'd1);
    end
  end

  assign lend = (col_r >= pairs_m1);
  assign fend = lend && (row_r >= {rows_m1, 1'b1});

  assign rdy3 = !s3_valid_r || out_pix.ready;
  assign rdy2 = !s2_valid_r || rdy3;
  assign rdy1 = !s1_valid_r || rdy2;
  assign in_pix.ready = rdy1;
  assign accept = in_pix.valid && rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pairs_r      <= y2r_pkg::LINE_PAIRS_RST;
      frame_row_pairs_r <= y2r_pkg::FRAME_ROW_PAIRS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        y2r_pkg::REG_LINE_PAIRS:      line_pairs_r      <= cfg_wdata;
        y2r_pkg::REG_FRAME_ROW_PAIRS: frame_row_pairs_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (lend) begin
        col_r <= '0;
        row_r <= fend ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!row_r[0]) begin
        chroma_mem[col_r] <= {in_pix.chroma_red, in_pix.chroma_blue};
      end
      rd_r <= chroma_mem[col_r];
    end
  end

  // stage 1: capture beat and position flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (rdy1) begin
      s1_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_y0_r   <= in_pix.luma_first;
      s1_y1_r   <= in_pix.luma_second;
      s1_cb_r   <= in_pix.chroma_blue;
      s1_cr_r   <= in_pix.chroma_red;
      s1_odd_r  <= row_r[0];
      s1_lend_r <= lend;
      s1_fend_r <= fend;
    end
  end

  // stage 2: chroma select and coefficient products
  assign cb_sel = s1_odd_r ? rd_r[PW-1:0]    : s1_cb_r;
  assign cr_sel = s1_odd_r ? rd_r[2*PW-1:PW] : s1_cr_r;
  assign y0_d = $signed({1'b0, s1_y0_r}) - y2r_pkg::LUMA_OFS;
  assign y1_d = $signed({1'b0, s1_y1_r}) - y2r_pkg::LUMA_OFS;
  assign u_d  = $signed({1'b0, cb_sel})  - y2r_pkg::CHROMA_OFS;
  assign v_d  = $signed({1'b0, cr_sel})  - y2r_pkg::CHROMA_OFS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (rdy2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid_r) begin
      s2_yp0_r  <= SW'(y0_d) * y2r_pkg::K_Y;
      s2_yp1_r  <= SW'(y1_d) * y2r_pkg::K_Y;
      s2_rv_r   <= SW'(v_d) * y2r_pkg::K_RV;
      s2_gu_r   <= SW'(u_d) * y2r_pkg::K_GU;
      s2_gv_r   <= SW'(v_d) * y2r_pkg::K_GV;
      s2_bu_r   <= SW'(u_d) * y2r_pkg::K_BU;
      s2_lend_r <= s1_lend_r;
      s2_fend_r <= s1_fend_r;
    end
  end

  // stage 3: sums, truncation and clamp into the output register
  assign r0 = s2_yp0_r + s2_rv_r;
  assign g0 = s2_yp0_r - s2_gu_r - s2_gv_r;
  assign b0 = s2_yp0_r + s2_bu_r;
  assign r1 = s2_yp1_r + s2_rv_r;
  assign g1 = s2_yp1_r - s2_gu_r - s2_gv_r;
  assign b1 = s2_yp1_r + s2_bu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (rdy3) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_valid_r) begin
      out_pix.red_first    <= to_channel(r0);
      out_pix.green_first  <= to_channel(g0);
      out_pix.blue_first   <= to_channel(b0);
      out_pix.red_second   <= to_channel(r1);
      out_pix.green_second <= to_channel(g1);
      out_pix.blue_second  <= to_channel(b1);
      out_pix.line_end     <= s2_lend_r;
      out_pix.frame_end    <= s2_fend_r;
    end
  end

  assign out_pix.valid = s3_valid_r;

endmodule

// ===== bench/yuy2_to_rgb32_converter_tb.sv =====
// ----------------------------------------------------------------------------
// yuy2_to_rgb32_converter_tb
// Self-checking bench for the YUY2 to RGB converter. A clocked driver feeds
// macropixels from a queue and a clocked monitor checks each result beat
// against a BT.601 predictor that keeps its own chroma line and counts.
// Register settings cover zero, one, the largest sizes and values above them.
// Changes are made only while the pipeline is empty, some of them mid-line
// and mid-frame. Both sides idle at random, and the receiver holds off once.
// ----------------------------------------------------------------------------
module yuy2_to_rgb32_converter_tb;

  localparam int MAX_PAIRS      = 2048;
  localparam int MAX_ROWS       = 2048;
  localparam int IDLE_LIMIT     = 3000;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int RANDOM_ITEMS   = 780;

  localparam longint Y_GAIN  = 76310;
  localparam longint CR_TO_R = 104595;
  localparam longint CB_TO_G = 25677;
  localparam longint CR_TO_G = 53281;
  localparam longint CB_TO_B = 132199;

  typedef struct packed {
    logic [y2r_pkg::PIX_W-1:0] luma_first;
    logic [y2r_pkg::PIX_W-1:0] chroma_blue;
    logic [y2r_pkg::PIX_W-1:0] luma_second;
    logic [y2r_pkg::PIX_W-1:0] chroma_red;
  } macropixel_t;

  typedef struct packed {
    logic [y2r_pkg::PIX_W-1:0] red_first;
    logic [y2r_pkg::PIX_W-1:0] green_first;
    logic [y2r_pkg::PIX_W-1:0] blue_first;
    logic [y2r_pkg::PIX_W-1:0] red_second;
    logic [y2r_pkg::PIX_W-1:0] green_second;
    logic [y2r_pkg::PIX_W-1:0] blue_second;
    logic                      line_end;
    logic                      frame_end;
  } rgb_pair_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [y2r_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [y2r_pkg::CFG_W-1:0]     cfg_wdata;

  y2r_yuy2_if in_if ();
  y2r_rgb_if  out_if ();

  yuy2_to_rgb32_converter #(
    .MAX_LINE_PAIRS(MAX_PAIRS),
    .MAX_ROW_PAIRS (MAX_ROWS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_if),
    .out_pix  (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [15:0]               chroma_store [MAX_PAIRS];
  bit                        chroma_valid [MAX_PAIRS];
  logic [10:0]               pair_col = '0;
  logic [11:0]               row_idx = '0;
  logic [y2r_pkg::CFG_W-1:0] line_pairs_reg = y2r_pkg::LINE_PAIRS_RST;
  logic [y2r_pkg::CFG_W-1:0] row_pairs_reg = y2r_pkg::FRAME_ROW_PAIRS_RST;

  macropixel_t macro_q [$];
  rgb_pair_t   rgb_expect_q [$];

  int   beats_issued = 0;
  int   beats_taken = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  int tx_mode = 0;
  int tx_wait = 0;
  bit tx_force_burst = 1'b0;
  int rx_mode = 0;
  int rx_wait = 0;
  int rx_hold_req = 0;
  int rx_hold_ack = 0;
  int rx_hold_left = 0;

  function automatic int effective_pairs(logic [y2r_pkg::CFG_W-1:0] v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return int'(v);
  endfunction

  function automatic logic [7:0] to_byte(longint sum);
    longint q;
    if (sum < 0) return 8'd0;
    q = sum / 65536;
    if (q > 255) q = 255;
    return q[7:0];
  endfunction

  function automatic logic [23:0] pixel_rgb(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr);
    longint yy;
    longint u;
    longint v;
    yy = luma;
    u = cb;
    v = cr;
    yy = Y_GAIN * (yy - 16);
    u = u - 128;
    v = v - 128;
    return {to_byte(yy + CR_TO_R * v), to_byte(yy - CB_TO_G * u - CR_TO_G * v),
            to_byte(yy + CB_TO_B * u)};
  endfunction

  function automatic rgb_pair_t predict_pair(macropixel_t beat);
    int        pairs;
    int        rows;
    logic [7:0] cb;
    logic [7:0] cr;
    rgb_pair_t res;
    pairs = effective_pairs(line_pairs_reg, MAX_PAIRS);
    rows = effective_pairs(row_pairs_reg, MAX_ROWS);
    if (!row_idx[0]) begin
      cb = beat.chroma_blue;
      cr = beat.chroma_red;
      chroma_store[pair_col] = {cr, cb};
      chroma_valid[pair_col] = 1'b1;
    end else begin
      {cr, cb} = chroma_store[pair_col];
    end
    {res.red_first, res.green_first, res.blue_first} = pixel_rgb(beat.luma_first, cb, cr);
    {res.red_second, res.green_second, res.blue_second} = pixel_rgb(beat.luma_second, cb, cr);
    res.line_end = (int'(pair_col) >= pairs - 1);
    res.frame_end = 1'b0;
    if (res.line_end) begin
      pair_col = '0;
      if (int'(row_idx) >= 2 * rows - 1) begin
        res.frame_end = 1'b1;
        row_idx = '0;
      end else begin
        row_idx = row_idx + 12'd1;
      end
    end else begin
      pair_col = pair_col + 11'd1;
    end
    return res;
  endfunction

  // an odd row must only read columns its even row has filled
  function automatic bit line_pairs_safe(logic [y2r_pkg::CFG_W-1:0] v);
    int hi;
    if (!row_idx[0]) return 1'b1;
    hi = effective_pairs(v, MAX_PAIRS) - 1;
    if (hi < int'(pair_col)) hi = int'(pair_col);
    for (int c = int'(pair_col); c <= hi; c++) begin
      if (!chroma_valid[c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int draw_wait(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 19)) : 0;
      default: return int'($urandom_range(0, 19));
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 7) != 0) return 8'($urandom());
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd16;
      2: return 8'd128;
      3: return 8'd235;
      4: return 8'd240;
      default: return 8'd255;
    endcase
  endfunction

  function automatic logic [y2r_pkg::CFG_W-1:0] draw_pairs_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 12'd0;
    if (r < 9) return 12'd4095;
    if (r < 12) return 12'd2048;
    if (r < 14) return 12'($urandom_range(2049, 4094));
    if (r < 70) return 12'($urandom_range(1, 6));
    return 12'($urandom_range(7, 40));
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // driver: a new beat is loaded once the last one is taken and its gap is over
  always @(negedge clk) begin : macro_drive
    logic        next_valid;
    macropixel_t beat;
    next_valid = in_if.valid;
    if (in_taken) next_valid = 1'b0;
    if (!next_valid && rst_n) begin
      if (tx_wait > 0) begin
        tx_wait--;
      end else if (macro_q.size() > 0) begin
        beat = macro_q.pop_front();
        in_if.luma_first <= beat.luma_first;
        in_if.chroma_blue <= beat.chroma_blue;
        in_if.luma_second <= beat.luma_second;
        in_if.chroma_red <= beat.chroma_red;
        next_valid = 1'b1;
        if ($urandom_range(0, 31) == 0) tx_mode = $urandom_range(0, 2);
        tx_wait = tx_force_burst ? 0 : draw_wait(tx_mode);
      end
    end
    in_if.valid <= next_valid;
  end

  always @(negedge clk) begin : rgb_ready_drive
    logic next_ready;
    if (out_taken) begin
      if ($urandom_range(0, 31) == 0) rx_mode = $urandom_range(0, 2);
      rx_wait = draw_wait(rx_mode);
    end
    if (rx_hold_ack != rx_hold_req) begin
      rx_hold_ack = rx_hold_req;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      next_ready = 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    out_if.ready <= next_ready;
  end

  always @(posedge clk) begin : beat_monitor
    rgb_pair_t   got;
    rgb_pair_t   want;
    macropixel_t beat;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.red_first, out_if.green_first, out_if.blue_first, out_if.red_second,
             out_if.green_second, out_if.blue_second, out_if.line_end, out_if.frame_end};
      if (rgb_expect_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = rgb_expect_q.pop_front();
        check_field("red_first", got.red_first, want.red_first);
        check_field("green_first", got.green_first, want.green_first);
        check_field("blue_first", got.blue_first, want.blue_first);
        check_field("red_second", got.red_second, want.red_second);
        check_field("green_second", got.green_second, want.green_second);
        check_field("blue_second", got.blue_second, want.blue_second);
        check_field("line_end", 8'(got.line_end), 8'(want.line_end));
        check_field("frame_end", 8'(got.frame_end), 8'(want.frame_end));
      end
      results_seen++;
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      beat = {in_if.luma_first, in_if.chroma_blue, in_if.luma_second, in_if.chroma_red};
      rgb_expect_q.push_back(predict_pair(beat));
      beats_taken++;
    end
    in_taken <= rst_n && in_if.valid && in_if.ready;
    out_taken <= rst_n && out_if.valid && out_if.ready;
    idle_cycles <= ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) ?
                   0 : idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("yuy2_to_rgb32_converter test failed");
    $finish;
  end

  task automatic push_beat(input logic [7:0] y0, input logic [7:0] cb, input logic [7:0] y1,
                           input logic [7:0] cr);
    macro_q.push_back({y0, cb, y1, cr});
    beats_issued++;
  endtask

  task automatic push_random(input int n);
    repeat (n) push_beat(rand_byte(), rand_byte(), rand_byte(), rand_byte());
  endtask

  task automatic drain();
    while (beats_taken != beats_issued || rgb_expect_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [y2r_pkg::CFG_IDX_W-1:0] idx,
                           input logic [y2r_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == y2r_pkg::REG_LINE_PAIRS) line_pairs_reg = value;
    else row_pairs_reg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_to_frame_end();
    int p;
    int r;
    int n;
    p = effective_pairs(line_pairs_reg, MAX_PAIRS);
    r = effective_pairs(row_pairs_reg, MAX_ROWS);
    n = (int'(pair_col) >= p - 1) ? 1 : p - int'(pair_col);
    if (int'(row_idx) < 2 * r - 1) n += (2 * r - 1 - int'(row_idx)) * p;
    push_random(n);
    drain();
  endtask

  initial begin : stimulus
    logic [y2r_pkg::CFG_W-1:0] v;
    int                        phase;
    int                        n;
    int                        random_issued;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.luma_first = '0;
    in_if.chroma_blue = '0;
    in_if.luma_second = '0;
    in_if.chroma_red = '0;
    out_if.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset sizes
    push_beat(8'd16, 8'd128, 8'd235, 8'd128);
    push_beat(8'd255, 8'd0, 8'd0, 8'd255);
    push_beat(8'd0, 8'd255, 8'd255, 8'd0);
    drain();

    // zero sizes act as one: every beat ends a line, rows alternate even/odd
    write_reg(y2r_pkg::REG_LINE_PAIRS, 12'd0);
    write_reg(y2r_pkg::REG_FRAME_ROW_PAIRS, 12'd0);
    push_beat(8'd128, 8'd16, 8'd128, 8'd240);
    push_beat(8'd235, 8'd0, 8'd16, 8'd255);
    push_beat(8'd16, 8'd128, 8'd235, 8'd128);
    push_beat(8'd235, 8'd0, 8'd16, 8'd255);
    push_beat(8'd255, 8'd255, 8'd255, 8'd255);
    push_beat(8'd0, 8'd0, 8'd0, 8'd0);
    push_beat(8'd0, 8'd0, 8'd0, 8'd0);
    push_beat(8'd255, 8'd255, 8'd255, 8'd255);
    push_beat(8'd255, 8'd0, 8'd0, 8'd255);
    push_beat(8'd128, 8'd255, 8'd128, 8'd0);
    push_beat(8'd0, 8'd255, 8'd255, 8'd0);
    push_beat(8'd16, 8'd16, 8'd240, 8'd240);
    drain();

    write_reg(y2r_pkg::REG_LINE_PAIRS, 12'd2);
    write_reg(y2r_pkg::REG_FRAME_ROW_PAIRS, 12'd2);
    push_beat(8'd235, 8'd240, 8'd16, 8'd16);
    push_beat(8'd1, 8'd127, 8'd254, 8'd129);
    push_beat(8'd170, 8'd85, 8'd85, 8'd170);
    push_beat(8'd85, 8'd170, 8'd170, 8'd85);
    push_random(4);
    drain();
    run_to_frame_end();

    // line size above the maximum acts as the maximum, then cut short mid-line
    write_reg(y2r_pkg::REG_LINE_PAIRS, 12'd4095);
    write_reg(y2r_pkg::REG_FRAME_ROW_PAIRS, 12'd1);
    push_random(40);
    drain();
    write_reg(y2r_pkg::REG_LINE_PAIRS, 12'd5);
    run_to_frame_end();

    // tallest frame, then shortened mid-frame
    write_reg(y2r_pkg::REG_LINE_PAIRS, 12'd3);
    write_reg(y2r_pkg::REG_FRAME_ROW_PAIRS, 12'd4095);
    push_random(30);
    drain();
    write_reg(y2r_pkg::REG_FRAME_ROW_PAIRS, 12'd2);
    push_random(12);
    drain();

    random_issued = 0;
    phase = 0;
    while (random_issued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        v = draw_pairs_value();
        if (line_pairs_safe(v)) write_reg(y2r_pkg::REG_LINE_PAIRS, v);
      end
      if ($urandom_range(0, 9) < 7) begin
        write_reg(y2r_pkg::REG_FRAME_ROW_PAIRS, draw_pairs_value());
      end
      n = $urandom_range(8, 60);
      if (phase == 2) begin
        // receiver stalls while the sender keeps offering beats
        tx_force_burst = 1'b1;
        rx_hold_req++;
        n = 50;
      end
      push_random(n);
      random_issued += n;
      drain();
      tx_force_burst = 1'b0;
      phase++;
    end

    repeat (8) @(negedge clk);
    if (rgb_expect_q.size() != 0) report_mismatch("expected results left over");
    if (mismatches == 0) begin
      $display("yuy2_to_rgb32_converter test passed");
    end else begin
      $display("yuy2_to_rgb32_converter test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/y2r_pkg.sv
rtl/core/y2r_yuy2_if.sv
rtl/core/y2r_rgb_if.sv
rtl/core/yuy2_to_rgb32_converter.sv
bench/yuy2_to_rgb32_converter_tb.sv
